@@ src/uvt_pkg.sv @@
// ----------------------------------------------------------------------------
// uvt_pkg
// Shared types and codes for the unique value table: command and response
// words, operation and status codes, and the cell control words.
// ----------------------------------------------------------------------------
package uvt_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_MODIFY = 3'd2;
    localparam logic [2:0] OP_SORT   = 3'd3;
    localparam logic [2:0] OP_SHOW   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_BADPOS   = 3'd5;

    // cell actions
    localparam logic [2:0] CA_HOLD   = 3'd0;
    localparam logic [2:0] CA_WRITE  = 3'd1;
    localparam logic [2:0] CA_SHIFT  = 3'd2;
    localparam logic [2:0] CA_ROTATE = 3'd3;
    localparam logic [2:0] CA_SORT   = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
        logic [5:0]         position;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         entry_count;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic               last;
    } rsp_t;

    // broadcast to every cell
    typedef struct packed {
        logic [2:0]  action;
        logic        phase;
        logic [31:0] key;
    } cell_ctl_t;

    // per-cell position flags, worked out by the sequencer
    typedef struct packed {
        logic sel_eq;
        logic sel_ge;
        logic used;
        logic pair_used;
        logic tail;
        logic pair_left;
        logic pair_right;
    } cell_flags_t;

endpackage

@@ src/uvt_cell.sv @@
// ----------------------------------------------------------------------------
// uvt_cell
// One table entry: holds a value, compares it with the broadcast key and
// with its right neighbour, takes the key on write, loads from its neighbours
// on shift and sort, and from its right neighbour or cell 0 on rotate.
// ----------------------------------------------------------------------------
module uvt_cell (
    input  logic                   clk,
    input  uvt_pkg::cell_ctl_t     ctl,
    input  uvt_pkg::cell_flags_t   flags,
    input  logic [31:0]            left_value,
    input  logic                   left_lt,
    input  logic [31:0]            right_value,
    input  logic [31:0]            first_value,
    output logic [31:0]            value,
    output logic                   lt_right,
    output logic                   match
);

    logic [31:0] value_reg;
    logic [31:0] value_next;

    assign value    = value_reg;
    assign lt_right = $signed(value_reg) < $signed(right_value);
    assign match    = flags.used && (value_reg == ctl.key);

    always_comb
    begin
        value_next = value_reg;
        unique case (ctl.action)
            uvt_pkg::CA_HOLD:
            begin
                value_next = value_reg;
            end
            uvt_pkg::CA_WRITE:
            begin
                if (flags.sel_eq)
                begin
                    value_next = ctl.key;
                end
            end
            uvt_pkg::CA_SHIFT:
            begin
                // close the gap left by the deleted entry
                if (flags.sel_ge && flags.pair_used)
                begin
                    value_next = right_value;
                end
            end
            uvt_pkg::CA_ROTATE:
            begin
                if (flags.pair_used)
                begin
                    value_next = right_value;
                end
                else if (flags.tail)
                begin
                    value_next = first_value;
                end
            end
            uvt_pkg::CA_SORT:
            begin
                // larger value moves towards position 0
                if (flags.pair_left && flags.pair_used && lt_right)
                begin
                    value_next = right_value;
                end
                else if (flags.pair_right && flags.used && left_lt)
                begin
                    value_next = left_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ src/unique_value_table_top.sv @@
// ----------------------------------------------------------------------------
// unique_value_table_top
// Table of distinct signed values held in a row of cells, with insert,
// delete, modify, descending sort and show, sequenced one word at a time.
// ----------------------------------------------------------------------------
// Insert, delete, modify and show of an empty table: one word, issued from the
//   execute state after acceptance; the next command is taken back in idle.
// Sort: DEPTH odd-even exchange steps, then one word.
// Show: count words from cell 0 as the row rotates, one a cycle while not stalled.
// Output stalls hold the show and execute states, not the sort steps. Reset clears
//   the entry count, the sequencer and the output valid; entry values are not reset.
module unique_value_table_top #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  uvt_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output uvt_pkg::rsp_t rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 6) ? CW : 6;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SORT = 2'd2;
    localparam logic [1:0] S_SHOW = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [IW-1:0]      cnt_reg;
    logic [IW-1:0]      cnt_next;
    logic [2:0]         op_reg;
    logic [31:0]        key_reg;
    logic [5:0]         pos_reg;
    uvt_pkg::rsp_t      rsp_reg;
    logic               rsp_valid_reg;

    uvt_pkg::cell_ctl_t   ctl;
    uvt_pkg::cell_flags_t flags [DEPTH];
    logic [IW-1:0]        sel;
    logic [31:0]          cell_value [DEPTH];
    logic                 cell_lt [DEPTH];
    logic [DEPTH-1:0]     match_vec;
    logic                 match_any;
    logic [IW-1:0]        match_idx;
    logic                 out_free;
    logic                 emit;
    uvt_pkg::rsp_t        word;
    logic                 accept;

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // values are distinct, so at most one cell matches
    assign match_any = |match_vec;
    always_comb
    begin
        match_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_vec[i])
            begin
                match_idx = match_idx | IW'(i);
            end
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic ODD = (i % 2) != 0;

        always_comb
        begin
            flags[i].sel_eq     = (sel == IW'(i));
            flags[i].sel_ge     = (sel <= IW'(i));
            flags[i].used       = (CW'(i) < count_reg);
            flags[i].pair_used  = (CW'(i + 1) < count_reg);
            flags[i].tail       = (CW'(i + 1) == count_reg);
            flags[i].pair_left  = (ctl.phase == ODD);
            flags[i].pair_right = (i != 0) && (ctl.phase != ODD);
        end

        uvt_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .flags       (flags[i]),
            .left_value  ((i == 0) ? cell_value[i] : cell_value[(i == 0) ? 0 : i - 1]),
            .left_lt     ((i == 0) ? 1'b0 : cell_lt[(i == 0) ? 0 : i - 1]),
            .right_value ((i == DEPTH - 1) ? cell_value[i]
                                           : cell_value[(i == DEPTH - 1) ? i : i + 1]),
            .first_value (cell_value[0]),
            .value       (cell_value[i]),
            .lt_right    (cell_lt[i]),
            .match       (match_vec[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cnt_next   = cnt_reg;
        ctl.action = uvt_pkg::CA_HOLD;
        ctl.phase  = cnt_reg[0];
        ctl.key    = key_reg;
        sel        = '0;
        emit       = 1'b0;
        word       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    case (cmd.operation) inside
                        uvt_pkg::OP_INSERT, uvt_pkg::OP_DELETE, uvt_pkg::OP_MODIFY:
                        begin
                            state_next = S_EXEC;
                        end
                        uvt_pkg::OP_SORT:
                        begin
                            state_next = S_SORT;
                        end
                        uvt_pkg::OP_SHOW:
                        begin
                            state_next = (count_reg == '0) ? S_EXEC : S_SHOW;
                        end
                        default:
                        begin
                            // drop unused codes
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SORT:
            begin
                ctl.action = uvt_pkg::CA_SORT;
                cnt_next   = cnt_reg + IW'(1);
                if (cnt_reg == IW'(DEPTH - 1))
                begin
                    state_next = S_EXEC;
                end
            end
            S_SHOW:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    ctl.action        = uvt_pkg::CA_ROTATE;
                    word.status       = uvt_pkg::ST_OK;
                    word.entry_count  = 5'(count_reg);
                    word.entry_index  = 4'(cnt_reg);
                    word.entry_value  = cell_value[0];
                    word.last         = (CW'(cnt_reg) + CW'(1)) == count_reg;
                    cnt_next          = cnt_reg + IW'(1);
                    if (word.last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    word.last  = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        uvt_pkg::OP_INSERT:
                        begin
                            sel = IW'(count_reg);
                            if (count_reg >= CW'(DEPTH))
                            begin
                                word.status = uvt_pkg::ST_FULL;
                            end
                            else if (match_any)
                            begin
                                word.status      = uvt_pkg::ST_DUP;
                                word.entry_index = 4'(match_idx);
                            end
                            else
                            begin
                                ctl.action  = uvt_pkg::CA_WRITE;
                                count_next  = count_reg + CW'(1);
                                word.status = uvt_pkg::ST_OK;
                            end
                        end
                        uvt_pkg::OP_DELETE:
                        begin
                            sel = match_idx;
                            if (count_reg == '0)
                            begin
                                word.status = uvt_pkg::ST_EMPTY;
                            end
                            else if (!match_any)
                            begin
                                word.status = uvt_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                ctl.action  = uvt_pkg::CA_SHIFT;
                                count_next  = count_reg - CW'(1);
                                word.status = uvt_pkg::ST_OK;
                            end
                        end
                        uvt_pkg::OP_MODIFY:
                        begin
                            sel = IW'(pos_reg);
                            if (PW'(pos_reg) >= PW'(count_reg))
                            begin
                                word.status = uvt_pkg::ST_BADPOS;
                            end
                            else if (match_any)
                            begin
                                word.status      = uvt_pkg::ST_DUP;
                                word.entry_index = 4'(match_idx);
                            end
                            else
                            begin
                                ctl.action  = uvt_pkg::CA_WRITE;
                                word.status = uvt_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            // sort done, or show of an empty table
                            word.status = uvt_pkg::ST_OK;
                        end
                    endcase
                    word.entry_count = 5'(count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= cmd.operation;
            key_reg <= cmd.value;
            pos_reg <= cmd.position;
        end
        if (emit)
        begin
            rsp_reg <= word;
        end
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unique value table. A tracker class keeps its
// own copy of the table, works out the response words of every accepted
// command and compares them, field by field and in order, with the block's
// output. Directed commands cover the empty, full, duplicate, not-found and
// bad-position cases, then biased random phases fill, churn and drain the
// table, with random command gaps and response stalls in all phases but the second.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 175;
    localparam int PHASE_ITEMS = 35;
    localparam int REPORT_MAX = 10;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    class table_tracker;
        logic signed [31:0] slots [TABLE_DEPTH];
        int unsigned fill = 0;
        uvt_pkg::rsp_t due_rsp_q [$];
        int unsigned errors = 0;

        function int find_slot(logic signed [31:0] v);
            for (int i = 0; i < fill; i++)
            begin
                if (slots[i] == v)
                    return i;
            end
            return -1;
        endfunction

        function void add_due(logic [2:0] st, int idx, logic signed [31:0] v, bit fin);
            uvt_pkg::rsp_t e;
            e.status      = st;
            e.entry_count = 5'(fill);
            e.entry_index = 4'(idx);
            e.entry_value = v;
            e.last        = fin;
            due_rsp_q.push_back(e);
        endfunction

        function int pending();
            return due_rsp_q.size();
        endfunction

        // update the table copy and queue the words this command will cause
        function void take_cmd(uvt_pkg::cmd_t c);
            int m;
            logic signed [31:0] t;
            case (c.operation)
                uvt_pkg::OP_INSERT:
                begin
                    m = find_slot(c.value);
                    if (fill >= TABLE_DEPTH)
                        add_due(uvt_pkg::ST_FULL, 0, 0, 1'b1);
                    else if (m >= 0)
                        add_due(uvt_pkg::ST_DUP, m, 0, 1'b1);
                    else
                    begin
                        slots[fill] = c.value;
                        fill++;
                        add_due(uvt_pkg::ST_OK, 0, 0, 1'b1);
                    end
                end
                uvt_pkg::OP_DELETE:
                begin
                    m = find_slot(c.value);
                    if (fill == 0)
                        add_due(uvt_pkg::ST_EMPTY, 0, 0, 1'b1);
                    else if (m < 0)
                        add_due(uvt_pkg::ST_NOTFOUND, 0, 0, 1'b1);
                    else
                    begin
                        fill--;
                        for (int i = m; i < fill; i++)
                            slots[i] = slots[i + 1];
                        add_due(uvt_pkg::ST_OK, 0, 0, 1'b1);
                    end
                end
                uvt_pkg::OP_MODIFY:
                begin
                    m = find_slot(c.value);
                    if (c.position >= fill)
                        add_due(uvt_pkg::ST_BADPOS, 0, 0, 1'b1);
                    else if (m >= 0)
                        add_due(uvt_pkg::ST_DUP, m, 0, 1'b1);
                    else
                    begin
                        slots[c.position] = c.value;
                        add_due(uvt_pkg::ST_OK, 0, 0, 1'b1);
                    end
                end
                uvt_pkg::OP_SORT:
                begin
                    for (int i = 0; i + 1 < fill; i++)
                    begin
                        for (int j = i + 1; j < fill; j++)
                        begin
                            if (slots[i] < slots[j])
                            begin
                                t = slots[i];
                                slots[i] = slots[j];
                                slots[j] = t;
                            end
                        end
                    end
                    add_due(uvt_pkg::ST_OK, 0, 0, 1'b1);
                end
                uvt_pkg::OP_SHOW:
                begin
                    if (fill == 0)
                        add_due(uvt_pkg::ST_OK, 0, 0, 1'b1);
                    for (int i = 0; i < fill; i++)
                        add_due(uvt_pkg::ST_OK, i, slots[i], i + 1 == fill);
                end
                default:
                    ; // unused codes: no word, no change
            endcase
        endfunction

        function void check_rsp(uvt_pkg::rsp_t got);
            uvt_pkg::rsp_t e;
            if (due_rsp_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected word: st=%0d cnt=%0d idx=%0d val=%0d last=%0b",
                             got.status, got.entry_count, got.entry_index,
                             got.entry_value, got.last);
                return;
            end
            e = due_rsp_q.pop_front();
            if (got.status !== e.status || got.entry_count !== e.entry_count ||
                got.entry_index !== e.entry_index || got.entry_value !== e.entry_value ||
                got.last !== e.last)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch st/cnt/idx/val/last: exp %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                             e.status, e.entry_count, e.entry_index, e.entry_value, e.last,
                             got.status, got.entry_count, got.entry_index,
                             got.entry_value, got.last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    uvt_pkg::cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    uvt_pkg::rsp_t rsp;

    table_tracker sb = new;
    bit idling = 1'b1;
    int stall_left = 0;
    int quiet = 0;

    unique_value_table_top #(
        .DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // mostly short holds, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idling && $urandom_range(0, 99) < 30)
        begin
            rsp_stall <= 1'b1;
            stall_left = pick_gap();
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_rsp(rsp);
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic uvt_pkg::cmd_t make_cmd(logic [2:0] op, logic signed [31:0] v,
                                               logic [5:0] p);
        uvt_pkg::cmd_t c;
        c.operation = op;
        c.value     = v;
        c.position  = p;
        return c;
    endfunction

    task automatic send_cmd(input uvt_pkg::cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        sb.take_cmd(c);
    endtask

    // hold the sender until every word owed has come back
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] fresh_value();
        logic signed [31:0] v;
        do v = $urandom; while (sb.find_slot(v) >= 0);
        return v;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && sb.fill > 0)
            return sb.slots[$urandom_range(0, sb.fill - 1)];
        if (r < 55)
        begin
            case ($urandom_range(0, 4))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 0;
                3: return -1;
                default: return 1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic uvt_pkg::cmd_t random_cmd(int ins_w, int del_w);
        uvt_pkg::cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        c.value = pick_value();
        if ($urandom_range(0, 99) < 70)
            c.position = 6'($urandom_range(0, sb.fill));
        else
            c.position = 6'($urandom_range(0, 63));
        if (r < ins_w)
            c.operation = uvt_pkg::OP_INSERT;
        else if (r < ins_w + del_w)
            c.operation = uvt_pkg::OP_DELETE;
        else if (r < 82)
            c.operation = uvt_pkg::OP_MODIFY;
        else if (r < 89)
            c.operation = uvt_pkg::OP_SORT;
        else if (r < 97)
            c.operation = uvt_pkg::OP_SHOW;
        else
            c.operation = 3'(uvt_pkg::OP_SHOW + $urandom_range(1, 3));
        return c;
    endfunction

    initial
    begin
        uvt_pkg::cmd_t c;
        int n;
        int ins_w;
        int del_w;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        send_cmd(make_cmd(uvt_pkg::OP_SHOW, 0, 0));
        send_cmd(make_cmd(uvt_pkg::OP_DELETE, 5, 0));
        send_cmd(make_cmd(uvt_pkg::OP_MODIFY, 7, 0));
        // extremes, then duplicates
        send_cmd(make_cmd(uvt_pkg::OP_INSERT, VAL_MIN, 0));
        send_cmd(make_cmd(uvt_pkg::OP_INSERT, VAL_MAX, 0));
        send_cmd(make_cmd(uvt_pkg::OP_INSERT, 0, 0));
        send_cmd(make_cmd(uvt_pkg::OP_INSERT, 0, 0));
        send_cmd(make_cmd(uvt_pkg::OP_MODIFY, VAL_MAX, 1));
        send_cmd(make_cmd(uvt_pkg::OP_MODIFY, 9, 63));
        send_cmd(make_cmd(uvt_pkg::OP_MODIFY, 9, 3));
        send_cmd(make_cmd(uvt_pkg::OP_MODIFY, -1, 2));
        send_cmd(make_cmd(uvt_pkg::OP_DELETE, 12345, 0));
        send_cmd(make_cmd(3'(uvt_pkg::OP_SHOW + 1), VAL_MAX, 63));
        send_cmd(make_cmd(3'(uvt_pkg::OP_SHOW + 3), -1, 63));
        send_cmd(make_cmd(uvt_pkg::OP_SORT, 0, 0));
        send_cmd(make_cmd(uvt_pkg::OP_SHOW, 0, 0));
        // first entry after the sort: the rest shift down
        send_cmd(make_cmd(uvt_pkg::OP_DELETE, VAL_MAX, 0));
        while (sb.fill < TABLE_DEPTH)
            send_cmd(make_cmd(uvt_pkg::OP_INSERT, fresh_value(), 0));
        send_cmd(make_cmd(uvt_pkg::OP_INSERT, fresh_value(), 0));
        send_cmd(make_cmd(uvt_pkg::OP_SORT, 0, 0));
        send_cmd(make_cmd(uvt_pkg::OP_SHOW, 0, 0));
        drain();

        for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++)
        begin
            case (p % 3)
                0: begin ins_w = 55; del_w = 10; end
                1: begin ins_w = 30; del_w = 28; end
                default: begin ins_w = 12; del_w = 50; end
            endcase
            idling = (p % 4) != 1;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                c = random_cmd(ins_w, del_w);
                send_cmd(c);
                if (c.operation <= uvt_pkg::OP_SHOW)
                    n++;
            end
            if (p % 2 == 1)
                drain();
        end

        cmd_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
src/uvt_pkg.sv
src/uvt_cell.sv
src/unique_value_table_top.sv
verif/tb_top.sv
